/* hw/rtl/arlm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arlm_pkg
// Shared constants, widths and types of the audio RMS level meter.
// ----------------------------------------------------------------------------
package arlm_pkg;

  // Frames accumulated per buffer at most
  localparam int unsigned MAX_FRAMES = 1024;

  // Frame position, square count and square sum widths
  localparam int unsigned POS_W   = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CNT_W   = $clog2(2 * MAX_FRAMES + 1);
  localparam int unsigned SQ_W    = 33;
  localparam int unsigned SUM_W   = SQ_W + $clog2(MAX_FRAMES);
  localparam int unsigned DIV_CW  = $clog2(SUM_W + 1);

  // Mean of squares never exceeds 2^32; its root fits 17 bits
  localparam int unsigned QUO_W   = 33;
  localparam int unsigned RAD_W   = 34;
  localparam int unsigned ROOT_W  = 17;
  localparam int unsigned SREM_W  = ROOT_W + 2;
  localparam int unsigned SQRT_CW = $clog2(ROOT_W + 1);

  // Smoothing weights in Q0.16 (0.93 and 0.07) and rounding offset
  localparam logic [15:0] SMOOTH_OLD  = 16'd60948;
  localparam logic [15:0] SMOOTH_NEW  = 16'd4588;
  localparam logic [31:0] SMOOTH_HALF = 32'd32768;

  // Channel modes
  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_MONO   = 2'd1;
  localparam logic [1:0] MODE_STEREO = 2'd2;

  // Register map
  localparam int unsigned ADDR_W           = 3;
  localparam logic        REG_CHANNEL_MODE = 1'b0;

  // Frame control travelling with the lane squares
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [1:0] mode;
    logic [1:0] cnt_inc;
  } arlm_frm_t;

  // Buffer close request toward the back stage
  typedef struct packed {
    logic valid;
    logic active;
  } arlm_close_t;

endpackage

/* hw/rtl/audio_rms_level_meter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_rms_level_meter
// Buffer RMS level meter with exponential smoothing. Two squaring lanes
// work on the left and right samples, a merge stage accumulates, and a back
// stage derives RMS, smoothed level and buffer count per buffer.
//
//   Channel   Direction  Contents
//   s_axis    in         tdata: left_sample, right_sample; tlast: last_frame
//   m_axis    out        tdata: rms_level, smoothed_level, buffers_seen
//   APB       in/out     register 0 at byte 0: channel_mode
//
// Frames within a buffer are taken one per cycle. After the last frame the
// input stalls until the back stage is idle again, while the
// one-bit-per-cycle divider and the bit-pair square root run.
// The result waits in an output register; a stalled output also holds the back
// stage after the next buffer close, and the input with it, not the frames before.
// Reset clears all accumulators, the smoothed level and the buffer counter.
// ----------------------------------------------------------------------------
module audio_rms_level_meter
  import arlm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // frame request stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,   // [15:0] left_sample, [31:16] right_sample
  input  logic              s_axis_tlast,   // last_frame
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [63:0]       m_axis_tdata,   // [15:0] rms_level, [31:16] smoothed_level,
                                            // [63:32] buffers_seen
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [1:0]       mode_q;
  logic [POS_W-1:0] pos_q, pos_d;
  arlm_frm_t        frm_q, frm_d;
  logic             accept;
  logic             in_limit;
  logic             en_left, en_right, scale;
  logic [SQ_W-1:0]  sq_l, sq_r;
  arlm_close_t      close;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] count;
  logic             back_idle;
  logic [15:0]      rms, smooth;
  logic [31:0]      buffers;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CHANNEL_MODE) ? {30'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_STEREO;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CHANNEL_MODE) begin
      mode_q <= pwdata[1:0];
    end
  end

  // Hold input while a buffer close is in flight
  assign s_axis_tready = back_idle && !(frm_q.valid && frm_q.last);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Drop frames past the limit; mode three counts as stereo
  always_comb begin
    in_limit = (pos_q < POS_W'(MAX_FRAMES));
    en_left  = in_limit && (mode_q != MODE_NONE);
    en_right = in_limit && mode_q[1];
    scale    = (mode_q == MODE_MONO);

    pos_d = pos_q;
    if (accept) begin
      if (s_axis_tlast) begin
        pos_d = '0;
      end else if (in_limit) begin
        pos_d = pos_q + 1'b1;
      end
    end

    frm_d.valid   = accept;
    frm_d.last    = s_axis_tlast;
    frm_d.mode    = mode_q;
    frm_d.cnt_inc = !in_limit ? 2'd0 : mode_q[1] ? 2'd2
                  : (mode_q == MODE_MONO) ? 2'd1 : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      frm_q <= '0;
    end else begin
      pos_q <= pos_d;
      frm_q <= frm_d;
    end
  end

  // Squaring lanes
  arlm_lane u_lane_left (
    .clk_i    (clk_i),
    .en_i     (accept && en_left),
    .scale_i  (scale),
    .sample_i (s_axis_tdata[15:0]),
    .square_o (sq_l)
  );

  arlm_lane u_lane_right (
    .clk_i    (clk_i),
    .en_i     (accept && en_right),
    .scale_i  (1'b0),
    .sample_i (s_axis_tdata[31:16]),
    .square_o (sq_r)
  );

  // Merge lanes into the buffer totals
  arlm_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frm_i   (frm_q),
    .sq_l_i  (sq_l),
    .sq_r_i  (sq_r),
    .close_o (close),
    .sum_o   (sum),
    .count_o (count)
  );

  // Per-buffer results
  arlm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .close_i     (close),
    .sum_i       (sum),
    .count_i     (count),
    .idle_o      (back_idle),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .rms_o       (rms),
    .smooth_o    (smooth),
    .buffers_o   (buffers)
  );

  assign m_axis_tdata = {buffers, smooth, rms};

endmodule

/* hw/rtl/arlm_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arlm_lane
// One squaring lane: registers the square of a Q1.15 sample, times four
// for a mono frame, or zero when the lane is not in use.
// ----------------------------------------------------------------------------
module arlm_lane
  import arlm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic                   scale_i,
  input  logic signed [15:0]     sample_i,
  output logic        [SQ_W-1:0] square_o
);

  logic signed [31:0] prod;
  logic [SQ_W-1:0]    square_d;
  logic [SQ_W-1:0]    square_q;

  // Square the sample and scale for mono
  always_comb begin
    prod = sample_i * sample_i;
    if (!en_i) begin
      square_d = '0;
    end else if (scale_i) begin
      square_d = {prod[30:0], 2'b00};
    end else begin
      square_d = {2'b00, prod[30:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    square_q <= square_d;
  end

  assign square_o = square_q;

endmodule

/* hw/rtl/arlm_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arlm_merge
// Merges the lane squares into the buffer sum and count, and hands the
// closing totals to the back stage on the last frame of a buffer.
// ----------------------------------------------------------------------------
module arlm_merge
  import arlm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  arlm_frm_t         frm_i,
  input  logic [SQ_W-1:0]   sq_l_i,
  input  logic [SQ_W-1:0]   sq_r_i,
  output arlm_close_t       close_o,
  output logic [SUM_W-1:0]  sum_o,
  output logic [CNT_W-1:0]  count_o
);

  logic [SUM_W-1:0] sum_q, sum_d, sum_new;
  logic [CNT_W-1:0] count_q, count_d, count_new;

  // Add both lanes to the running totals
  always_comb begin
    sum_new   = sum_q + SUM_W'(sq_l_i) + SUM_W'(sq_r_i);
    count_new = count_q + CNT_W'(frm_i.cnt_inc);
    sum_d     = sum_q;
    count_d   = count_q;
    if (frm_i.valid) begin
      if (frm_i.last) begin
        sum_d   = '0;
        count_d = '0;
      end else begin
        sum_d   = sum_new;
        count_d = count_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

  // Close the buffer with the totals that include the last frame
  assign close_o.valid  = frm_i.valid & frm_i.last;
  assign close_o.active = (frm_i.mode != MODE_NONE);
  assign sum_o          = sum_new;
  assign count_o        = count_new;

endmodule

/* hw/rtl/arlm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arlm_back
// Per-buffer back stage: bit-serial divide of the square sum by the count,
// bit-pair square root, smoothing MAC, buffer counter and result register.
// ----------------------------------------------------------------------------
module arlm_back
  import arlm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  arlm_close_t       close_i,
  input  logic [SUM_W-1:0]  sum_i,
  input  logic [CNT_W-1:0]  count_i,
  output logic              idle_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [15:0]       rms_o,
  output logic [15:0]       smooth_o,
  output logic [31:0]       buffers_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_MUL,
    ST_MAC,
    ST_OUT
  } state_e;

  state_e state_q, state_d;

  // Control and registered outputs
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_rms_q, out_rms_d;
  logic [15:0] out_smooth_q, out_smooth_d;
  logic [31:0] out_buf_q, out_buf_d;
  logic [15:0] smooth_q, smooth_d;
  logic [31:0] bufcnt_q, bufcnt_d;

  // Datapath
  logic [CNT_W-1:0]   divisor_q, divisor_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic [SUM_W-1:0]   quo_q, quo_d;
  logic [DIV_CW-1:0]  div_cnt_q, div_cnt_d;
  logic [RAD_W-1:0]   rad_q, rad_d;
  logic [SREM_W-1:0]  srem_q, srem_d;
  logic [ROOT_W-1:0]  root_q, root_d;
  logic [SQRT_CW-1:0] sq_cnt_q, sq_cnt_d;
  logic [15:0]        rms_q, rms_d;
  logic [31:0]        prod_q, prod_d;

  // Step temporaries
  logic [CNT_W:0]     div_trial;
  logic               div_ge;
  logic [CNT_W:0]     div_diff;
  logic [SREM_W+1:0]  sq_trial;
  logic [SREM_W+1:0]  sq_sub;
  logic               sq_ge;
  logic [SREM_W+1:0]  sq_diff;
  logic [32:0]        mac;
  logic               out_free;

  always_comb begin
    // one restoring division step
    div_trial = {rem_q, quo_q[SUM_W-1]};
    div_ge    = (div_trial >= {1'b0, divisor_q});
    div_diff  = div_trial - {1'b0, divisor_q};
    // one square root step over the next bit pair
    sq_trial  = {srem_q, rad_q[RAD_W-1 -: 2]};
    sq_sub    = (SREM_W + 2)'({root_q, 2'b01});
    sq_ge     = (sq_trial >= sq_sub);
    sq_diff   = sq_trial - sq_sub;
    // smoothing accumulate with rounding
    mac       = {1'b0, prod_q} + 33'(32'(SMOOTH_NEW) * 32'(rms_q)) + 33'(SMOOTH_HALF);
    out_free  = !out_valid_q || out_ready_i;

    state_d      = state_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_rms_d    = out_rms_q;
    out_smooth_d = out_smooth_q;
    out_buf_d    = out_buf_q;
    smooth_d     = smooth_q;
    bufcnt_d     = bufcnt_q;
    divisor_d    = divisor_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    div_cnt_d    = div_cnt_q;
    rad_d        = rad_q;
    srem_d       = srem_q;
    root_d       = root_q;
    sq_cnt_d     = sq_cnt_q;
    rms_d        = rms_q;
    prod_d       = prod_q;

    case (state_q)
      ST_IDLE: begin
        if (close_i.valid) begin
          rms_d     = '0;
          divisor_d = count_i;
          quo_d     = sum_i;
          rem_d     = '0;
          div_cnt_d = DIV_CW'(SUM_W - 1);
          if (!close_i.active) begin
            state_d = ST_OUT;
          end else if (count_i == '0) begin
            state_d = ST_MUL;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        quo_d     = {quo_q[SUM_W-2:0], div_ge};
        rem_d     = div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
        div_cnt_d = div_cnt_q - 1'b1;
        if (div_cnt_q == '0) begin
          rad_d    = {1'b0, quo_d[QUO_W-1:0]};
          srem_d   = '0;
          root_d   = '0;
          sq_cnt_d = SQRT_CW'(ROOT_W - 1);
          state_d  = ST_SQRT;
        end
      end
      ST_SQRT: begin
        rad_d    = {rad_q[RAD_W-3:0], 2'b00};
        srem_d   = sq_ge ? sq_diff[SREM_W-1:0] : sq_trial[SREM_W-1:0];
        root_d   = {root_q[ROOT_W-2:0], sq_ge};
        sq_cnt_d = sq_cnt_q - 1'b1;
        if (sq_cnt_q == '0) begin
          // saturate a root of exactly one
          rms_d   = root_d[ROOT_W-1] ? 16'hFFFF : root_d[15:0];
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = 32'(SMOOTH_OLD) * 32'(smooth_q);
        state_d = ST_MAC;
      end
      ST_MAC: begin
        smooth_d = mac[31:16];
        bufcnt_d = bufcnt_q + 32'd1;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        // hold until the result register is free
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_rms_d    = rms_q;
          out_smooth_d = smooth_q;
          out_buf_d    = bufcnt_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, smoothing state, counter and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      out_rms_q    <= '0;
      out_smooth_q <= '0;
      out_buf_q    <= '0;
      smooth_q     <= '0;
      bufcnt_q     <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      out_rms_q    <= out_rms_d;
      out_smooth_q <= out_smooth_d;
      out_buf_q    <= out_buf_d;
      smooth_q     <= smooth_d;
      bufcnt_q     <= bufcnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    divisor_q <= divisor_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    div_cnt_q <= div_cnt_d;
    rad_q     <= rad_d;
    srem_q    <= srem_d;
    root_q    <= root_d;
    sq_cnt_q  <= sq_cnt_d;
    rms_q     <= rms_d;
    prod_q    <= prod_d;
  end

  assign idle_o      = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign rms_o       = out_rms_q;
  assign smooth_o    = out_smooth_q;
  assign buffers_o   = out_buf_q;

endmodule
